// File: design/ths_pkg.sv
`timescale 1ns / 1ps
package ths_pkg;

    localparam int MAX_DIM     = 256;
    localparam int DIM_W       = 9;
    localparam int COORD_W     = 8;
    localparam int ADDR_W      = 16;
    localparam int FRAC_BITS   = 8;
    localparam int SCALE_FRAC  = 16;
    localparam int GRID_W      = 30;
    localparam int PROD_W      = 45;
    localparam int OUT_W       = 24;
    localparam int HEIGHT_OFFSET = 5 << FRAC_BITS;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [1:0] {
        CFG_MAP_WIDTH,
        CFG_MAP_HEIGHT,
        CFG_INV_SCALE,
        CFG_HEIGHT_SCALE
    } ths_cfg_idx_t;

    // clamped corner coordinates plus what travels with them
    typedef struct packed {
        logic                  is_query;
        logic                  in_terrain;
        logic                  upper;
        logic [FRAC_BITS-1:0]  dx;
        logic [FRAC_BITS-1:0]  dz;
        logic [COORD_W-1:0]    x0;
        logic [COORD_W-1:0]    x1;
        logic [COORD_W-1:0]    z0;
        logic [COORD_W-1:0]    z1;
        logic [ADDR_W-1:0]     waddr;
        logic [7:0]            wdata;
    } ths_corner_t;

    typedef struct packed {
        logic                  is_query;
        logic                  in_terrain;
        logic                  upper;
        logic [FRAC_BITS-1:0]  dx;
        logic [FRAC_BITS-1:0]  dz;
    } ths_ctl_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0)
            r = DIM_W'(1);
        else if (d > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = d;
        return r;
    endfunction

endpackage

// File: design/ths_grid.sv
`timescale 1ns / 1ps
module ths_grid
    import ths_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      func,
    input  logic [ADDR_W-1:0]         texel_address,
    input  logic [7:0]                texel_value,
    input  logic signed [19:0]        x_world,
    input  logic signed [19:0]        z_world,
    input  logic [23:0]               inv_plane_scale,
    input  logic [DIM_W-1:0]          w_eff,
    input  logic [DIM_W-1:0]          h_eff,
    output logic                      out_valid,
    output ths_corner_t               corner
);

    localparam int IX_W = GRID_W - FRAC_BITS;

    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic signed [IX_W:0] c,
        input logic [DIM_W-1:0]     dim
    );
        logic signed [IX_W:0] lim;
        logic [COORD_W-1:0]   r;
        lim = $signed({{(IX_W+1-DIM_W){1'b0}}, dim}) - (IX_W+1)'(1);
        if (c < 0)
            r = '0;
        else if (c > lim)
            r = lim[COORD_W-1:0];
        else
            r = c[COORD_W-1:0];
        return r;
    endfunction

    // stage 1: captured item
    logic                     s1_valid_reg;
    logic                     s1_func_reg;
    logic [ADDR_W-1:0]        s1_addr_reg;
    logic [7:0]               s1_value_reg;
    logic signed [19:0]       s1_x_reg;
    logic signed [19:0]       s1_z_reg;

    // stage 2: scaled products
    logic                     s2_valid_reg;
    logic                     s2_func_reg;
    logic [ADDR_W-1:0]        s2_addr_reg;
    logic [7:0]               s2_value_reg;
    logic signed [PROD_W-1:0] px_reg;
    logic signed [PROD_W-1:0] pz_reg;
    logic signed [PROD_W-1:0] px_next;
    logic signed [PROD_W-1:0] pz_next;

    // stage 3: grid coordinates
    logic                     s3_valid_reg;
    logic                     s3_func_reg;
    logic [ADDR_W-1:0]        s3_addr_reg;
    logic [7:0]               s3_value_reg;
    logic signed [GRID_W-1:0] gx_reg;
    logic signed [GRID_W-1:0] gz_reg;
    logic signed [GRID_W-1:0] gx_next;
    logic signed [GRID_W-1:0] gz_next;

    // stage 4: clamped corners
    logic                     s4_valid_reg;
    ths_corner_t              corner_reg;
    ths_corner_t              corner_next;
    logic signed [IX_W:0]     ix0;
    logic signed [IX_W:0]     iz0;
    logic signed [IX_W:0]     ix1;
    logic signed [IX_W:0]     iz1;
    logic [FRAC_BITS:0]       dsum;
    logic [GRID_W-2:0]        w_lim;
    logic [GRID_W-2:0]        h_lim;

    always_comb
    begin
        px_next = s1_x_reg * $signed({1'b0, inv_plane_scale});
        pz_next = s1_z_reg * $signed({1'b0, inv_plane_scale});
        gx_next = GRID_W'(px_reg >>> SCALE_FRAC)
                + GRID_W'({w_eff, {(FRAC_BITS-1){1'b0}}});
        gz_next = GRID_W'(pz_reg >>> SCALE_FRAC)
                + GRID_W'({h_eff, {(FRAC_BITS-1){1'b0}}});
    end

    always_comb
    begin
        ix0   = {gx_reg[GRID_W-1], gx_reg[GRID_W-1:FRAC_BITS]};
        iz0   = {gz_reg[GRID_W-1], gz_reg[GRID_W-1:FRAC_BITS]};
        ix1   = ix0 + (IX_W+1)'(1);
        iz1   = iz0 + (IX_W+1)'(1);
        dsum  = {1'b0, gx_reg[FRAC_BITS-1:0]} + {1'b0, gz_reg[FRAC_BITS-1:0]};
        w_lim = (GRID_W-1)'({w_eff, {FRAC_BITS{1'b0}}});
        h_lim = (GRID_W-1)'({h_eff, {FRAC_BITS{1'b0}}});

        corner_next.is_query   = (s3_func_reg == FUNC_QUERY);
        corner_next.in_terrain = !gx_reg[GRID_W-1] && !gz_reg[GRID_W-1]
                               && (gx_reg[GRID_W-2:0] <= w_lim)
                               && (gz_reg[GRID_W-2:0] <= h_lim);
        corner_next.upper      = dsum[FRAC_BITS];
        corner_next.dx         = gx_reg[FRAC_BITS-1:0];
        corner_next.dz         = gz_reg[FRAC_BITS-1:0];
        corner_next.x0         = clamp_coord(ix0, w_eff);
        corner_next.x1         = clamp_coord(ix1, w_eff);
        corner_next.z0         = clamp_coord(iz0, h_eff);
        corner_next.z1         = clamp_coord(iz1, h_eff);
        corner_next.waddr      = s3_addr_reg;
        corner_next.wdata      = s3_value_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_func_reg  <= func;
        s1_addr_reg  <= texel_address;
        s1_value_reg <= texel_value;
        s1_x_reg     <= x_world;
        s1_z_reg     <= z_world;

        s2_func_reg  <= s1_func_reg;
        s2_addr_reg  <= s1_addr_reg;
        s2_value_reg <= s1_value_reg;
        px_reg       <= px_next;
        pz_reg       <= pz_next;

        s3_func_reg  <= s2_func_reg;
        s3_addr_reg  <= s2_addr_reg;
        s3_value_reg <= s2_value_reg;
        gx_reg       <= gx_next;
        gz_reg       <= gz_next;

        corner_reg   <= corner_next;
    end

    assign out_valid = s4_valid_reg;
    assign corner    = corner_reg;

endmodule

// File: design/ths_store.sv
`timescale 1ns / 1ps
module ths_store
    import ths_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  ths_corner_t       corner,
    input  logic [DIM_W-1:0]  w_eff,
    output logic              out_valid,
    output ths_ctl_t          ctl,
    output logic [7:0]        h_c,
    output logic [7:0]        h_10,
    output logic [7:0]        h_01
);

    localparam int DEPTH = 1 << ADDR_W;

    // two copies: a serves the shared corners, b the lower or upper one
    logic [7:0]            mem_a [0:DEPTH-1];
    logic [7:0]            mem_b [0:DEPTH-1];

    logic [COORD_W+DIM_W-1:0] row0;
    logic [COORD_W+DIM_W-1:0] row1;
    logic [ADDR_W-1:0]     addr_10;
    logic [ADDR_W-1:0]     addr_01;
    logic [ADDR_W-1:0]     addr_c;
    logic                  wr_en;

    logic                  valid_reg;
    ths_ctl_t              ctl_reg;
    logic [7:0]            h_c_reg;
    logic [7:0]            h_10_reg;
    logic [7:0]            h_01_reg;

    always_comb
    begin
        row0    = corner.z0 * w_eff;
        row1    = corner.z1 * w_eff;
        addr_10 = row0[ADDR_W-1:0] + ADDR_W'(corner.x1);
        addr_01 = row1[ADDR_W-1:0] + ADDR_W'(corner.x0);
        if (corner.upper)
            addr_c = row1[ADDR_W-1:0] + ADDR_W'(corner.x1);
        else
            addr_c = row0[ADDR_W-1:0] + ADDR_W'(corner.x0);
        wr_en   = in_valid && !corner.is_query;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[corner.waddr] <= corner.wdata;
            mem_b[corner.waddr] <= corner.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        h_10_reg <= mem_a[addr_10];
        h_01_reg <= mem_a[addr_01];
        h_c_reg  <= mem_b[addr_c];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        ctl_reg.is_query   <= corner.is_query;
        ctl_reg.in_terrain <= corner.in_terrain;
        ctl_reg.upper      <= corner.upper;
        ctl_reg.dx         <= corner.dx;
        ctl_reg.dz         <= corner.dz;
    end

    assign out_valid = valid_reg;
    assign ctl       = ctl_reg;
    assign h_c       = h_c_reg;
    assign h_10      = h_10_reg;
    assign h_01      = h_01_reg;

endmodule

// File: design/ths_interp.sv
`timescale 1ns / 1ps
module ths_interp
    import ths_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  ths_ctl_t          ctl,
    input  logic [7:0]        h_c,
    input  logic [7:0]        h_10,
    input  logic [7:0]        h_01,
    input  logic [15:0]       level_gain,
    output logic              out_valid,
    output logic [OUT_W-1:0]  terrain_height,
    output logic              in_terrain,
    output logic              is_query
);

    localparam int V_W = 16;

    logic [7:0]             ea;
    logic [7:0]             eb;
    logic [FRAC_BITS:0]     fa;
    logic [FRAC_BITS:0]     fb;
    logic signed [8:0]      da;
    logic signed [8:0]      db;
    logic signed [18:0]     pa;
    logic signed [18:0]     pb;
    logic signed [20:0]     v_sum;
    logic [V_W-1:0]         v_next;

    logic                   s1_valid_reg;
    ths_ctl_t               s1_ctl_reg;
    logic [V_W-1:0]         v_reg;

    logic [31:0]            prod;
    logic [OUT_W:0]         hsum;
    logic [OUT_W-1:0]       height_next;

    logic                   valid_reg;
    logic [OUT_W-1:0]       terrain_height_reg;
    logic                   in_terrain_reg;
    logic                   is_query_reg;

    // lower triangle weights dx, dz; upper triangle 1-dx, 1-dz
    always_comb
    begin
        if (ctl.upper)
        begin
            ea = h_01;
            eb = h_10;
            fa = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, ctl.dx};
            fb = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, ctl.dz};
        end
        else
        begin
            ea = h_10;
            eb = h_01;
            fa = {1'b0, ctl.dx};
            fb = {1'b0, ctl.dz};
        end
        da    = $signed({1'b0, ea}) - $signed({1'b0, h_c});
        db    = $signed({1'b0, eb}) - $signed({1'b0, h_c});
        pa    = da * $signed({1'b0, fa});
        pb    = db * $signed({1'b0, fb});
        v_sum = $signed({5'b0, h_c, {FRAC_BITS{1'b0}}}) + pa + pb;
        if (v_sum < 0)
            v_next = '0;
        else
            v_next = v_sum[V_W-1:0];
    end

    always_comb
    begin
        prod = v_reg * level_gain;
        hsum = {1'b0, prod[31:FRAC_BITS]} + (OUT_W+1)'(HEIGHT_OFFSET);
        if (!s1_ctl_reg.is_query)
            height_next = '0;
        else if (hsum[OUT_W])
            height_next = '1;
        else
            height_next = hsum[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            valid_reg    <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ctl_reg         <= ctl;
        v_reg              <= v_next;
        terrain_height_reg <= height_next;
        in_terrain_reg     <= s1_ctl_reg.is_query && s1_ctl_reg.in_terrain;
        is_query_reg       <= s1_ctl_reg.is_query;
    end

    assign out_valid      = valid_reg;
    assign terrain_height = terrain_height_reg;
    assign in_terrain     = in_terrain_reg;
    assign is_query       = is_query_reg;

endmodule

// File: design/terrain_height_sampler.sv
`timescale 1ns / 1ps
// channel   | handshake            | payload
// ----------+----------------------+--------------------------------------------
// item in   | start, busy          | func, texel_address, texel_value,
//           |                      | x_world, z_world
// result    | done (one cycle)     | terrain_height, in_terrain, is_query
// config    | cfg_we               | cfg_index, cfg_data
//
// one item per cycle; busy stays low, so start may be high every cycle
// a result shows on done once its item has passed the registered pipeline stages:
// capture, multiply, grid, clamp, store read, interpolate, scale
// each store copy is read at its single registered read stage, writes land there in order
// reset clears the pipeline valid bits and loads the config registers with defaults; the height store is not cleared
// the receiver cannot stall, so nothing holds results back
module terrain_height_sampler
    import ths_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                func,
    input  logic [ADDR_W-1:0]   texel_address,
    input  logic [7:0]          texel_value,
    input  logic signed [19:0]  x_world,
    input  logic signed [19:0]  z_world,
    output logic                done,
    output logic [OUT_W-1:0]    terrain_height,
    output logic                in_terrain,
    output logic                is_query,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_data
);

    logic [DIM_W-1:0]  map_width_reg;
    logic [DIM_W-1:0]  map_height_reg;
    logic [23:0]       inv_plane_scale_reg;
    logic [15:0]       level_gain_reg;

    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic              accept;

    logic              grid_valid;
    ths_corner_t       corner;
    logic              store_valid;
    ths_ctl_t          store_ctl;
    logic [7:0]        h_c;
    logic [7:0]        h_10;
    logic [7:0]        h_01;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg       <= DIM_W'(256);
            map_height_reg      <= DIM_W'(256);
            inv_plane_scale_reg <= 24'd65536;
            level_gain_reg      <= 16'd256;
        end
        else if (cfg_we)
        begin
            case (ths_cfg_idx_t'(cfg_index))
                CFG_MAP_WIDTH:    map_width_reg       <= cfg_data[DIM_W-1:0];
                CFG_MAP_HEIGHT:   map_height_reg      <= cfg_data[DIM_W-1:0];
                CFG_INV_SCALE:    inv_plane_scale_reg <= cfg_data;
                CFG_HEIGHT_SCALE: level_gain_reg      <= cfg_data[15:0];
                default:          map_width_reg       <= map_width_reg;
            endcase
        end
    end

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign w_eff  = eff_dim(map_width_reg);
    assign h_eff  = eff_dim(map_height_reg);

    ths_grid u_grid (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (accept),
        .func            (func),
        .texel_address   (texel_address),
        .texel_value     (texel_value),
        .x_world         (x_world),
        .z_world         (z_world),
        .inv_plane_scale (inv_plane_scale_reg),
        .w_eff           (w_eff),
        .h_eff           (h_eff),
        .out_valid       (grid_valid),
        .corner          (corner)
    );

    ths_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (grid_valid),
        .corner    (corner),
        .w_eff     (w_eff),
        .out_valid (store_valid),
        .ctl       (store_ctl),
        .h_c       (h_c),
        .h_10      (h_10),
        .h_01      (h_01)
    );

    ths_interp u_interp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (store_valid),
        .ctl            (store_ctl),
        .h_c            (h_c),
        .h_10           (h_10),
        .h_01           (h_01),
        .level_gain     (level_gain_reg),
        .out_valid      (done),
        .terrain_height (terrain_height),
        .in_terrain     (in_terrain),
        .is_query       (is_query)
    );

endmodule
